[rtl/core/rgb_lamp_mode_sequencer_defines.svh]
// Assertion macros used by the lamp mode sequencer RTL.
`ifndef RGB_LAMP_MODE_SEQUENCER_DEFINES_SVH
`define RGB_LAMP_MODE_SEQUENCER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RLMS_ASSERT_NOW(label, clock, resetn, cond, expr) \
    label: assert property (@(posedge clock) disable iff (!resetn) (cond) |-> (expr)) \
        else $error("lamp sequencer check failed (same cycle)");

// Next-cycle implication, disabled while reset is asserted.
`define RLMS_ASSERT_NEXT(label, clock, resetn, cond, expr) \
    label: assert property (@(posedge clock) disable iff (!resetn) (cond) |=> (expr)) \
        else $error("lamp sequencer check failed (next cycle)");

`endif

[rtl/core/rlms_pkg.sv]
// Types and constants of the lamp mode sequencer.
`default_nettype none
package rlms_pkg;

    // Lamp drive word: idle, blue, green, red
    typedef struct packed {
        logic idle;
        logic blue;
        logic green;
        logic red;
    } lamp_t;

    localparam lamp_t LAMP_IDLE  = '{idle: 1'b1, blue: 1'b0, green: 1'b0, red: 1'b0};
    localparam lamp_t LAMP_RED   = '{idle: 1'b0, blue: 1'b0, green: 1'b0, red: 1'b1};
    localparam lamp_t LAMP_GREEN = '{idle: 1'b0, blue: 1'b0, green: 1'b1, red: 1'b0};
    localparam lamp_t LAMP_BLUE  = '{idle: 1'b0, blue: 1'b1, green: 1'b0, red: 1'b0};
    localparam lamp_t LAMP_ALL   = '{idle: 1'b0, blue: 1'b1, green: 1'b1, red: 1'b1};

    // Lamp modes
    localparam logic [2:0] MODE_OFF    = 3'd0;
    localparam logic [2:0] MODE_ALL    = 3'd1;
    localparam logic [2:0] MODE_RED    = 3'd2;
    localparam logic [2:0] MODE_BLUE   = 3'd3;
    localparam logic [2:0] MODE_GREEN  = 3'd4;
    localparam logic [2:0] MODE_SLOW   = 3'd5;
    localparam logic [2:0] MODE_MEDIUM = 3'd6;
    localparam logic [2:0] MODE_FAST   = 3'd7;

    // Configuration register indexes
    localparam logic [2:0] REG_HOLD_RELOAD    = 3'd0;
    localparam logic [2:0] REG_RELEASE_RELOAD = 3'd1;
    localparam logic [2:0] REG_SLOW_PERIOD    = 3'd2;
    localparam logic [2:0] REG_MEDIUM_PERIOD  = 3'd3;
    localparam logic [2:0] REG_FAST_PERIOD    = 3'd4;

    // Reset values
    localparam logic [15:0] HOLD_RELOAD_RST    = 16'd5000;
    localparam logic [15:0] RELEASE_RELOAD_RST = 16'd50;
    localparam logic [15:0] SLOW_PERIOD_RST    = 16'd3000;
    localparam logic [15:0] MEDIUM_PERIOD_RST  = 16'd1500;
    localparam logic [15:0] FAST_PERIOD_RST    = 16'd600;
    localparam logic [15:0] SLOW_ONE_RST       = 16'd1000;
    localparam logic [15:0] SLOW_TWO_RST       = 16'd2000;
    localparam logic [15:0] MEDIUM_ONE_RST     = 16'd500;
    localparam logic [15:0] MEDIUM_TWO_RST     = 16'd1000;
    localparam logic [15:0] FAST_ONE_RST       = 16'd200;
    localparam logic [15:0] FAST_TWO_RST       = 16'd400;

    // Divide-by-three reciprocal, exact for all 17-bit numerators
    localparam logic [16:0] THIRD_MAGIC = 17'd87382;
    localparam int          THIRD_SHIFT = 18;

    // Period of one cycle mode with its event points
    typedef struct packed {
        logic [15:0] period;
        logic [15:0] one_third;
        logic [15:0] two_third;
    } cycle_cfg_t;

    // Register file contents seen by the step logic
    typedef struct packed {
        logic [15:0] hold_reload;
        logic [15:0] release_reload;
        cycle_cfg_t  slow;
        cycle_cfg_t  mid;
        cycle_cfg_t  fast;
    } cfg_t;

    // Floor of a 17-bit value divided by three
    function automatic logic [15:0] div3(input logic [16:0] value);
        logic [33:0] product;
        product = {17'd0, value} * {17'd0, THIRD_MAGIC};
        return product[THIRD_SHIFT +: 16];
    endfunction

endpackage
`default_nettype wire

[rtl/core/rgb_lamp_mode_sequencer.sv]
// RGB lamp mode sequencer: 1 ms button ticks in, lamp drives and mode out.
//
// Input channel: one transaction per tick, carrying button_pressed.
// Output channel: one transaction per tick with red_on, green_on, blue_on,
// idle_on and mode_now, the state after that tick.
// Configuration: write transactions on cfg_valid/cfg_ready with cfg_index
// and cfg_data; cfg_ready is always high. Indexes 0..4 select hold reload,
// release reload, slow, medium and fast period; other indexes are dropped.
// Each period write also loads its one-third and two-third points in the
// same cycle, so a tick may follow the write directly.
// The result is valid in the cycle after its input transaction. Throughput:
// one tick per cycle while out_stall is low; the state registers act as
// the result register and the tick-to-tick path is one hold-counter compare
// feeding the shared cycle counter decrement and compares.
// Stall: while a result waits under out_stall, in_stall is raised and the
// state holds; a new tick is taken in the cycle the result leaves.
// Reset (rst_n low, asynchronous): registers return to their defaults,
// mode 0, idle lamp lit, no result pending.
`default_nettype none
`include "rgb_lamp_mode_sequencer_defines.svh"
module rgb_lamp_mode_sequencer (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        button_pressed,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             red_on,
    output logic             green_on,
    output logic             blue_on,
    output logic             idle_on,
    output logic [2:0]       mode_now,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);
    import rlms_pkg::*;

    cfg_t   cfg;
    lamp_t  lamp;
    logic   accept;
    logic   out_valid_reg, out_valid_next;

    rlms_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Stall input only while a result is held back
    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;

    rlms_step u_step (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (accept),
        .button_pressed (button_pressed),
        .cfg            (cfg),
        .lamp           (lamp),
        .mode           (mode_now)
    );

    // Result valid: set on accept, drop once taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    assign out_valid = out_valid_reg;
    assign red_on    = lamp.red;
    assign green_on  = lamp.green;
    assign blue_on   = lamp.blue;
    assign idle_on   = lamp.idle;

    // Idle lamp never shares with a colour
    `RLMS_ASSERT_NOW(a_idle_excl, clk, rst_n, out_valid && idle_on, !(red_on || green_on || blue_on))
    // Fixed colour modes show their colour set
    `RLMS_ASSERT_NOW(a_mode_all, clk, rst_n, out_valid && (mode_now == MODE_ALL), red_on && green_on && blue_on)
    `RLMS_ASSERT_NOW(a_mode_red, clk, rst_n, out_valid && (mode_now == MODE_RED), red_on && !green_on && !blue_on)
    // Every accepted tick yields a result next cycle
    `RLMS_ASSERT_NEXT(a_accept_result, clk, rst_n, in_valid && !in_stall, out_valid)

endmodule
`default_nettype wire

[rtl/core/rlms_cfg_regs.sv]
// Configuration registers with precomputed one-third and two-third points.
`default_nettype none
module rlms_cfg_regs (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cfg_valid,
    output logic               cfg_ready,
    input  wire logic [2:0]    cfg_index,
    input  wire logic [15:0]   cfg_data,
    output rlms_pkg::cfg_t     cfg
);
    import rlms_pkg::*;

    cfg_t        cfg_reg;
    cycle_cfg_t  cycle_new;

    // Always take a write transaction
    assign cfg_ready = 1'b1;

    // Derive event points of the incoming period
    always_comb
    begin
        cycle_new.period    = cfg_data;
        cycle_new.one_third = div3({1'b0, cfg_data});
        cycle_new.two_third = div3({cfg_data, 1'b0});
    end

    // Store the written register; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.hold_reload    <= HOLD_RELOAD_RST;
            cfg_reg.release_reload <= RELEASE_RELOAD_RST;
            cfg_reg.slow.period    <= SLOW_PERIOD_RST;
            cfg_reg.slow.one_third <= SLOW_ONE_RST;
            cfg_reg.slow.two_third <= SLOW_TWO_RST;
            cfg_reg.mid.period     <= MEDIUM_PERIOD_RST;
            cfg_reg.mid.one_third  <= MEDIUM_ONE_RST;
            cfg_reg.mid.two_third  <= MEDIUM_TWO_RST;
            cfg_reg.fast.period    <= FAST_PERIOD_RST;
            cfg_reg.fast.one_third <= FAST_ONE_RST;
            cfg_reg.fast.two_third <= FAST_TWO_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_HOLD_RELOAD:    cfg_reg.hold_reload    <= cfg_data;
                REG_RELEASE_RELOAD: cfg_reg.release_reload <= cfg_data;
                REG_SLOW_PERIOD:    cfg_reg.slow           <= cycle_new;
                REG_MEDIUM_PERIOD:  cfg_reg.mid            <= cycle_new;
                REG_FAST_PERIOD:    cfg_reg.fast           <= cycle_new;
                default:            ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule
`default_nettype wire

[rtl/core/rlms_step.sv]
// Per-tick state update: hold counter, lamp mode and cycle counters.
`default_nettype none
module rlms_step (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          accept,
    input  wire logic          button_pressed,
    input  rlms_pkg::cfg_t     cfg,
    output rlms_pkg::lamp_t    lamp,
    output logic [2:0]         mode
);
    import rlms_pkg::*;

    logic [15:0] hold_reg,   hold_next;
    logic [2:0]  mode_reg,   mode_next;
    lamp_t       lamp_reg,   lamp_next;
    logic [15:0] slow_reg,   slow_next;
    logic [15:0] medium_reg, medium_next;
    logic [15:0] fast_reg,   fast_next;

    logic        wrap;
    logic [15:0] hold_dec;
    logic [15:0] cyc_count;
    cycle_cfg_t  cyc_cfg;
    logic [15:0] cyc_dec;
    logic [15:0] cyc_count_new;
    lamp_t       cyc_lamp;

    // Hold counter and mode advance
    always_comb
    begin
        hold_dec  = hold_reg - 16'd1;
        hold_next = hold_reg;
        mode_next = mode_reg;
        wrap      = 1'b0;
        if (accept)
        begin
            if (button_pressed)
            begin
                if (hold_dec == 16'd0)
                begin
                    hold_next = cfg.hold_reload;
                    if (mode_reg == MODE_FAST)
                        wrap = 1'b1;
                    else
                        mode_next = mode_reg + 3'd1;
                end
                else
                begin
                    hold_next = hold_dec;
                end
            end
            else
            begin
                hold_next = cfg.release_reload;
            end
            if (wrap)
                mode_next = MODE_OFF;
        end
    end

    // Select the cycle counter of the new mode
    always_comb
    begin
        unique case (mode_next)
            MODE_SLOW:
            begin
                cyc_count = slow_reg;
                cyc_cfg   = cfg.slow;
            end
            MODE_MEDIUM:
            begin
                cyc_count = medium_reg;
                cyc_cfg   = cfg.mid;
            end
            default:
            begin
                cyc_count = fast_reg;
                cyc_cfg   = cfg.fast;
            end
        endcase
    end

    // Shared cycle unit: decrement and check event points, zero first
    always_comb
    begin
        cyc_dec       = cyc_count - 16'd1;
        cyc_count_new = cyc_dec;
        cyc_lamp      = lamp_reg;
        priority if (cyc_dec == 16'd0)
        begin
            cyc_lamp      = LAMP_GREEN;
            cyc_count_new = cyc_cfg.period;
        end
        else if (cyc_dec == cyc_cfg.one_third)
        begin
            cyc_lamp = LAMP_BLUE;
        end
        else if (cyc_dec == cyc_cfg.two_third)
        begin
            cyc_lamp = LAMP_RED;
        end
        else
        begin
            cyc_lamp = lamp_reg;
        end
    end

    // Lamp drive and cycle counter write-back
    always_comb
    begin
        lamp_next   = lamp_reg;
        slow_next   = slow_reg;
        medium_next = medium_reg;
        fast_next   = fast_reg;
        if (accept)
        begin
            if (wrap)
            begin
                lamp_next = LAMP_IDLE;
            end
            else
            begin
                unique case (mode_next)
                    MODE_OFF:    lamp_next = lamp_reg;
                    MODE_ALL:    lamp_next = LAMP_ALL;
                    MODE_RED:    lamp_next = LAMP_RED;
                    MODE_BLUE:   lamp_next = LAMP_BLUE;
                    MODE_GREEN:  lamp_next = LAMP_GREEN;
                    MODE_SLOW:
                    begin
                        lamp_next = cyc_lamp;
                        slow_next = cyc_count_new;
                    end
                    MODE_MEDIUM:
                    begin
                        lamp_next   = cyc_lamp;
                        medium_next = cyc_count_new;
                    end
                    MODE_FAST:
                    begin
                        lamp_next = cyc_lamp;
                        fast_next = cyc_count_new;
                    end
                endcase
            end
        end
    end

    // Hold state; it doubles as the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_reg   <= HOLD_RELOAD_RST;
            mode_reg   <= MODE_OFF;
            lamp_reg   <= LAMP_IDLE;
            slow_reg   <= SLOW_PERIOD_RST;
            medium_reg <= MEDIUM_PERIOD_RST;
            fast_reg   <= FAST_PERIOD_RST;
        end
        else
        begin
            hold_reg   <= hold_next;
            mode_reg   <= mode_next;
            lamp_reg   <= lamp_next;
            slow_reg   <= slow_next;
            medium_reg <= medium_next;
            fast_reg   <= fast_next;
        end
    end

    assign lamp = lamp_reg;
    assign mode = mode_reg;

endmodule
`default_nettype wire
